// ===== hw/rtl/cmap4_pkg.sv =====
// Shared types and constants for the cmap format-4 glyph lookup core.
package cmap4_pkg;

	localparam int MAX_SEGMENTS     = 64;
	localparam int SEG_AW           = $clog2(MAX_SEGMENTS);
	localparam int IDX_W            = SEG_AW + 1;
	localparam int WORD_STORE_DEPTH = 1024;
	localparam int WORD_AW          = $clog2(WORD_STORE_DEPTH);
	localparam int COUNT_W          = 7;
	localparam int CODE_W           = 16;
	// code plus half offset plus segment index needs 17 bits; one more for the borrow
	localparam int ALU_W            = 18;

	localparam logic [1:0] ACT_LOOKUP    = 2'd0;
	localparam logic [1:0] ACT_LOAD_SEG  = 2'd1;
	localparam logic [1:0] ACT_LOAD_WORD = 2'd2;

	localparam logic [1:0] STAT_MAPPED     = 2'd0;
	localparam logic [1:0] STAT_BELOW      = 2'd1;
	localparam logic [1:0] STAT_NO_SEGMENT = 2'd2;
	localparam logic [1:0] STAT_RANGE      = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic [5:0]         segment_index;
		logic [15:0]        last_code;
		logic [15:0]        first_code;
		logic signed [15:0] glyph_delta;
		logic [9:0]         word_index;
		logic [15:0]        word_value;
		logic [15:0]        char_code;
	} in_item_t;

	typedef struct packed {
		logic [15:0] glyph_id;
		logic [1:0]  status;
	} out_item_t;

	typedef struct packed {
		logic [CODE_W-1:0] last_code;
		logic [CODE_W-1:0] first_code;
		logic [CODE_W-1:0] delta;
	} seg_entry_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_START,
		S_RANGE,
		S_ADDR,
		S_GLYPH,
		S_FIN
	} state_t;

endpackage

// ===== hw/rtl/cmap4_alu.sv =====
// Shared add/subtract unit used for every code compare and address or glyph sum.
module cmap4_alu (
	input  cmap4_pkg::alu_req_t            req,
	output logic [cmap4_pkg::ALU_W-1:0]    y
);
	import cmap4_pkg::*;

	always_comb begin
		if (req.sub) begin
			y = req.a - req.b;
		end else begin
			y = req.a + req.b;
		end
	end

endmodule

// ===== hw/rtl/cmap_format4_glyph_lookup_core.sv =====
// Top level of the cmap format-4 glyph lookup core: sequencer, tables, output register.
//
// Usage: in_data carries one item per transfer (in_valid high, in_stall low).
// A segment load or a word load is written at the transfer edge and gives no
// result; the core stays ready, so loads go at one per cycle.
// A lookup walks the segment table through one read port, one segment per
// cycle, then reads the range offset and, when it is nonzero, the glyph word
// from the word store, all through one shared adder. It ends early when the
// code is below the segment start, when the range offset is zero or when the
// glyph word would lie past the store; a code that no segment covers ends
// once the walk finds no match. in_stall stays high until the result has
// moved into the output register.
// out_data is held in a register until out_stall is low; the next item is
// accepted while that result waits, and a later lookup stalls at its end
// only if the earlier result is still not taken.
// cfg_we writes segment_count (values above 64 act as 64); write it only while idle,
// which the core does not enforce. Reset clears the sequencer and output valid and
// sets segment_count to 1; the tables hold nothing defined until loaded.
module cmap_format4_glyph_lookup_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  cmap4_pkg::in_item_t               in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output cmap4_pkg::out_item_t              out_data,
	input  logic                              cfg_we,
	input  logic [cmap4_pkg::COUNT_W-1:0]     cfg_wdata
);
	import cmap4_pkg::*;

	state_t st_q, st_d;

	logic [COUNT_W-1:0] count_q;
	logic [IDX_W-1:0]   used;
	logic [IDX_W-1:0]   idx_q;
	logic [SEG_AW-1:0]  cur_q;
	logic               rd_vld_q;
	logic [CODE_W-1:0]  code_q;
	logic [SEG_AW-1:0]  seg_i_q;
	logic [CODE_W-1:0]  start_q;
	logic [CODE_W-1:0]  delta_q;
	logic [CODE_W-1:0]  diff_q;
	logic               rng_ok_q;
	logic [ALU_W-1:0]   acc_q;
	out_item_t          res_q, res_d;
	logic               res_we;
	out_item_t          out_q;
	logic               out_valid_q;

	seg_entry_t         seg_mem [MAX_SEGMENTS];
	seg_entry_t         seg_rd_q;
	logic [CODE_W-1:0]  word_mem [WORD_STORE_DEPTH];
	logic [CODE_W-1:0]  word_rd_q;

	logic               in_xfer;
	logic               seg_we, word_we;
	logic               seg_re, word_re;
	logic [SEG_AW-1:0]  seg_ra;
	logic [WORD_AW-1:0] word_ra;
	alu_req_t           alu_req;
	logic [ALU_W-1:0]   alu_y;
	logic               borrow;
	logic               hit;
	logic [CODE_W-1:0]  range_word;
	logic               oob;
	logic               out_free;

	cmap4_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = (st_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign used     = (int'(count_q) > MAX_SEGMENTS) ? IDX_W'(MAX_SEGMENTS) : IDX_W'(count_q);
	assign borrow   = alu_y[ALU_W-1];
	assign hit      = rd_vld_q && !borrow;
	assign range_word = rng_ok_q ? word_rd_q : '0;
	assign oob      = (int'(alu_y) >= WORD_STORE_DEPTH);

	assign seg_we  = in_xfer && (in_data.action == ACT_LOAD_SEG) &&
		(int'(in_data.segment_index) < MAX_SEGMENTS);
	assign word_we = in_xfer && (in_data.action == ACT_LOAD_WORD) &&
		(int'(in_data.word_index) < WORD_STORE_DEPTH);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				if (in_xfer && (in_data.action == ACT_LOOKUP)) begin
					st_d = (used == '0) ? S_FIN : S_WALK;
				end
			end
			S_WALK: begin
				if (hit) begin
					st_d = S_START;
				end else if (!rd_vld_q && (idx_q >= used)) begin
					st_d = S_FIN;
				end
			end
			S_START: st_d = borrow ? S_FIN : S_RANGE;
			S_RANGE: st_d = (range_word == '0) ? S_FIN : S_ADDR;
			S_ADDR:  st_d = oob ? S_FIN : S_GLYPH;
			S_GLYPH: st_d = S_FIN;
			S_FIN: begin
				if (out_free) begin
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	// datapath control: memory reads, adder operands, result capture
	always_comb begin
		seg_re  = 1'b0;
		seg_ra  = idx_q[SEG_AW-1:0];
		word_re = 1'b0;
		word_ra = WORD_AW'(seg_i_q);
		alu_req = '{a: '0, b: '0, sub: 1'b0};
		res_we  = 1'b0;
		res_d   = '{glyph_id: '0, status: STAT_NO_SEGMENT};
		case (st_q)
			S_IDLE: begin
				res_we = in_xfer && (in_data.action == ACT_LOOKUP) && (used == '0);
			end
			S_WALK: begin
				seg_re  = (idx_q < used);
				alu_req = '{a: ALU_W'(seg_rd_q.last_code), b: ALU_W'(code_q), sub: 1'b1};
				res_we  = !hit && !rd_vld_q && (idx_q >= used);
			end
			S_START: begin
				alu_req = '{a: ALU_W'(code_q), b: ALU_W'(start_q), sub: 1'b1};
				word_re = 1'b1;
				res_we  = borrow;
				res_d   = '{glyph_id: '0, status: STAT_BELOW};
			end
			S_RANGE: begin
				if (range_word == '0) begin
					alu_req = '{a: ALU_W'(code_q), b: ALU_W'(delta_q), sub: 1'b0};
					res_we  = 1'b1;
					res_d   = '{glyph_id: alu_y[CODE_W-1:0], status: STAT_MAPPED};
				end else begin
					alu_req = '{a: ALU_W'(seg_i_q), b: ALU_W'(range_word >> 1), sub: 1'b0};
				end
			end
			S_ADDR: begin
				alu_req = '{a: acc_q, b: ALU_W'(diff_q), sub: 1'b0};
				word_re = !oob;
				word_ra = alu_y[WORD_AW-1:0];
				res_we  = oob;
				res_d   = '{glyph_id: '0, status: STAT_RANGE};
			end
			S_GLYPH: begin
				alu_req = '{a: ALU_W'(word_rd_q), b: ALU_W'(delta_q), sub: 1'b0};
				res_we  = 1'b1;
				res_d   = '{glyph_id: (word_rd_q == '0) ? '0 : alu_y[CODE_W-1:0],
					status: STAT_MAPPED};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			count_q     <= COUNT_W'(1);
			idx_q       <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (st_q == S_IDLE) begin
				idx_q    <= '0;
				rd_vld_q <= 1'b0;
			end else if (st_q == S_WALK) begin
				rd_vld_q <= seg_re;
				if (seg_re) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			if ((st_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer && (in_data.action == ACT_LOOKUP)) begin
			code_q <= in_data.char_code;
		end
		if (st_q == S_WALK) begin
			cur_q <= idx_q[SEG_AW-1:0];
			if (hit) begin
				seg_i_q <= cur_q;
				start_q <= seg_rd_q.first_code;
				delta_q <= seg_rd_q.delta;
			end
		end
		if (st_q == S_START) begin
			diff_q   <= alu_y[CODE_W-1:0];
			rng_ok_q <= (int'(seg_i_q) < WORD_STORE_DEPTH);
		end
		if (st_q == S_RANGE) begin
			acc_q <= alu_y;
		end
		if (res_we) begin
			res_q <= res_d;
		end
		if ((st_q == S_FIN) && out_free) begin
			out_q <= res_q;
		end
	end

	// segment table
	always_ff @(posedge clk) begin
		if (seg_we) begin
			seg_mem[in_data.segment_index[SEG_AW-1:0]] <= '{
				last_code:  in_data.last_code,
				first_code: in_data.first_code,
				delta:      in_data.glyph_delta
			};
		end
		if (seg_re) begin
			seg_rd_q <= seg_mem[seg_ra];
		end
	end

	// range offset / glyph id store
	always_ff @(posedge clk) begin
		if (word_we) begin
			word_mem[WORD_AW'(in_data.word_index)] <= in_data.word_value;
		end
		if (word_re) begin
			word_rd_q <= word_mem[word_ra];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (in_data.action == ACT_LOOKUP) |=> in_stall)
		else $error("lookup transfer did not start the sequencer");

	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (in_data.action != ACT_LOOKUP) |=> !in_stall)
		else $error("load transfer left the core busy");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_WALK) |-> (idx_q <= used))
		else $error("segment walk ran past the segment count");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == S_FIN))
		else $error("result appeared outside the finish step");

endmodule

// ===== tb/cmap_format4_glyph_lookup_core_tb.sv =====
// Self-checking testbench for the cmap format-4 glyph lookup core.
`timescale 1ns / 1ps

module cmap_format4_glyph_lookup_core_tb;
	import cmap4_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 1000000;

	// Mirror of the segment table and word store; predicts one result per lookup.
	class glyph_map_board;
		logic [15:0]        last_codes [MAX_SEGMENTS];
		logic [15:0]        first_codes [MAX_SEGMENTS];
		logic [15:0]        deltas [MAX_SEGMENTS];
		logic [15:0]        store_words [WORD_STORE_DEPTH];
		logic [COUNT_W-1:0] used_count;
		out_item_t          due_glyphs[$];
		int                 mismatches;

		function new();
			used_count = 1;
			mismatches = 0;
		endfunction

		function out_item_t lookup_glyph(logic [15:0] code);
			out_item_t   r;
			int          used;
			int          at;
			logic [15:0] range_off;
			logic [15:0] w;
			used = (used_count > MAX_SEGMENTS) ? MAX_SEGMENTS : used_count;
			r.glyph_id = '0;
			r.status = STAT_NO_SEGMENT;
			for (int i = 0; i < used; i++) begin
				if (last_codes[i] >= code) begin
					if (code < first_codes[i]) begin
						r.status = STAT_BELOW;
					end else begin
						range_off = store_words[i];
						r.status = STAT_MAPPED;
						if (range_off == 0) begin
							r.glyph_id = code + deltas[i];
						end else begin
							at = i + range_off / 2 + (code - first_codes[i]);
							if (at >= WORD_STORE_DEPTH) begin
								r.status = STAT_RANGE;
							end else begin
								w = store_words[at];
								r.glyph_id = (w != 0) ? w + deltas[i] : 16'h0000;
							end
						end
					end
					return r;
				end
			end
			return r;
		endfunction

		function void note_item(in_item_t it);
			case (it.action)
				ACT_LOOKUP: due_glyphs.push_back(lookup_glyph(it.char_code));
				ACT_LOAD_SEG: begin
					last_codes[it.segment_index] = it.last_code;
					first_codes[it.segment_index] = it.first_code;
					deltas[it.segment_index] = it.glyph_delta;
				end
				ACT_LOAD_WORD: store_words[it.word_index] = it.word_value;
				default: ;
			endcase
		endfunction

		function void check_glyph(out_item_t got);
			out_item_t want;
			if (due_glyphs.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual glyph %h status %0d",
					$time, got.glyph_id, got.status);
				mismatches++;
				return;
			end
			want = due_glyphs.pop_front();
			if (got.glyph_id !== want.glyph_id) begin
				$display("%0t: glyph_id mismatch: expected %h, actual %h",
					$time, want.glyph_id, got.glyph_id);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, want.status, got.status);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_stall;
	out_item_t          out_data;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;

	glyph_map_board board;
	int             tx_idle_pct;
	int             rx_idle_pct;
	bit             hold_go = 1'b0;
	int             cycle_count = 0;
	int             tbl_end [MAX_SEGMENTS];
	int             tbl_start [MAX_SEGMENTS];
	int             tbl_n = 1;

	cmap_format4_glyph_lookup_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			board.note_item(in_data);
		if (arst_n && out_valid && !out_stall)
			board.check_glyph(out_data);
		if (arst_n && cfg_we)
			board.used_count = cfg_wdata;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("cmap_format4_glyph_lookup_core test failed");
			$finish;
		end
	end

	// Result side: random stall, or one long hold-off on request.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	function automatic in_item_t random_item();
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		return raw[$bits(in_item_t)-1:0];
	endfunction

	function automatic in_item_t make_seg(input int idx, input logic [15:0] e,
		input logic [15:0] s, input logic [15:0] d);
		in_item_t it;
		it = random_item();
		it.action = ACT_LOAD_SEG;
		it.segment_index = 6'(idx);
		it.last_code = e;
		it.first_code = s;
		it.glyph_delta = d;
		return it;
	endfunction

	function automatic in_item_t make_word(input int idx, input logic [15:0] v);
		in_item_t it;
		it = random_item();
		it.action = ACT_LOAD_WORD;
		it.word_index = 10'(idx);
		it.word_value = v;
		return it;
	endfunction

	function automatic in_item_t make_lookup(input logic [15:0] code);
		in_item_t it;
		it = random_item();
		it.action = ACT_LOOKUP;
		it.char_code = code;
		return it;
	endfunction

	// Codes clustered on segment edges of the current table.
	function automatic logic [15:0] pick_code();
		int j;
		j = $urandom_range(tbl_n - 1);
		case ($urandom_range(9))
			0: return 16'(tbl_start[j]);
			1: return 16'(tbl_end[j]);
			2: return 16'(tbl_end[j] + 1);
			3: return 16'(tbl_start[j] - 1);
			4: return 16'($urandom);
			default: return 16'($urandom_range(tbl_end[j], tbl_start[j]));
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (board.due_glyphs.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(input int count);
		cfg_we <= 1'b1;
		cfg_wdata <= count[COUNT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed table: ascending end codes, last usually 0xffff, some segments
	// indirect through glyph words placed after the range offsets.
	task automatic load_table(input int count);
		int n, prev, lo, hi, end_c, span, gpos, offset;
		bit indirect;
		n = (count > MAX_SEGMENTS) ? MAX_SEGMENTS : ((count < 1) ? 1 : count);
		prev = -1;
		gpos = n;
		for (int i = 0; i < n; i++) begin
			lo = prev + 1;
			hi = 65535 - (n - 1 - i);
			if (hi > lo + 131072 / n)
				hi = lo + 131072 / n;
			end_c = $urandom_range(hi, lo);
			if (i == n - 1 && $urandom_range(3) != 0)
				end_c = 65535;
			indirect = 1'($urandom_range(1));
			span = $urandom_range(indirect ? 3 : end_c - lo + 1);
			if (span > end_c)
				span = end_c;
			offset = 0;
			if (indirect) begin
				if ($urandom_range(7) == 0) begin
					// offset past the store: every hit is out of range
					offset = 2 * $urandom_range(32767, WORD_STORE_DEPTH) + $urandom_range(1);
				end else if (gpos + span < WORD_STORE_DEPTH) begin
					offset = 2 * (gpos - i) + $urandom_range(1);
					for (int g = 0; g <= span; g++)
						send_item(make_word(gpos + g,
							($urandom_range(5) == 0) ? 16'h0000 : 16'($urandom)));
					gpos += span + 1;
				end
			end
			tbl_end[i] = end_c;
			tbl_start[i] = ($urandom_range(15) == 0) ? end_c + 1 : end_c - span;
			send_item(make_seg(i, 16'(end_c), 16'(tbl_start[i]), 16'($urandom)));
			send_item(make_word(i, 16'(offset)));
			prev = end_c;
		end
		tbl_n = n;
	endtask

	task automatic run_phase(input int count, input int lookups, input bit squeeze);
		in_item_t it;
		write_count(count);
		load_table(count);
		if (squeeze)
			hold_go = 1'b1;
		repeat (lookups) begin
			if ($urandom_range(9) < 8) begin
				it = make_lookup(pick_code());
			end else begin
				// noise: stray loads and the unused action; stray loads stay
				// clear of the live segments and range offsets
				it = random_item();
				it.action = 2'($urandom_range(3, 1));
				if (it.action == ACT_LOAD_SEG) begin
					if (tbl_n < MAX_SEGMENTS)
						it.segment_index = 6'($urandom_range(MAX_SEGMENTS - 1, tbl_n));
					else
						it.action = ACT_UNUSED;
				end else if (it.action == ACT_LOAD_WORD) begin
					it.word_index = 10'($urandom_range(WORD_STORE_DEPTH - 1, tbl_n));
				end
			end
			send_item(it);
		end
		settle();
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		tx_idle_pct = 21;
		rx_idle_pct = 85;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_count(2);
		send_item(make_seg(0, 16'h00ff, 16'h0010, 16'h8000));
		send_item(make_seg(1, 16'hfffe, 16'hfff0, 16'h7fff));
		send_item(make_word(0, 16'h0000));
		send_item(make_word(1, 16'd18));
		send_item(make_word(10, 16'h1234));
		send_item(make_word(11, 16'h0000));
		send_item(make_word(24, 16'hfedc));
		send_item(make_word(1023, 16'hffff));
		send_item(make_lookup(16'h0000));   // below first start
		send_item(make_lookup(16'h0010));   // delta wraps
		send_item(make_lookup(16'h00ff));
		send_item(make_lookup(16'h0100));   // gap between segments
		send_item(make_lookup(16'hfff0));   // through glyph word
		send_item(make_lookup(16'hfff1));   // zero glyph word
		send_item(make_lookup(16'hfffe));
		send_item(make_lookup(16'hffff));   // past last end
		send_item(make_word(1, 16'hffff));
		send_item(make_lookup(16'hfff0));   // word index out of range
		send_item(make_word(1, 16'h0000));
		send_item(make_lookup(16'hfffe));
		send_item(make_seg(0, 16'h0005, 16'h0009, 16'h0001));
		send_item(make_lookup(16'h0005));   // start above end
		send_item(make_lookup(16'h0003));
		begin
			in_item_t junk;
			junk = random_item();
			junk.action = ACT_UNUSED;
			send_item(junk);
		end
		settle();

		run_phase(9, 15, 1'b0);
		run_phase(0, 8, 1'b0);
		run_phase(4, 12, 1'b0);

		tx_idle_pct = 85;
		rx_idle_pct = 21;
		run_phase(10, 15, 1'b0);
		run_phase(1, 10, 1'b0);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase(127, 25, 1'b1);
		run_phase(3, 12, 1'b0);

		if (board.due_glyphs.size() != 0) begin
			$display("%0t: missing results: expected %0d more, actual 0",
				$time, board.due_glyphs.size());
			board.mismatches++;
		end
		if (board.mismatches == 0)
			$display("cmap_format4_glyph_lookup_core test passed");
		else
			$display("cmap_format4_glyph_lookup_core test failed");
		$finish;
	end

endmodule

// ===== cmap_format4_glyph_lookup_core.f =====
hw/rtl/cmap4_pkg.sv
hw/rtl/cmap4_alu.sv
hw/rtl/cmap_format4_glyph_lookup_core.sv
tb/cmap_format4_glyph_lookup_core_tb.sv
